/* sv/bpsd_pkg.sv */
// Package for the bit pattern score detector.
// Sizes, class codes, register map and control structs; no dependencies.
package bpsd_pkg;

    localparam int HISTORY_BITS = 64;
    localparam int LEN_W        = 7;
    localparam int SCORE_W      = 16;
    localparam int CNT_W        = $clog2(HISTORY_BITS + 1);
    localparam int GRP_SIZE     = 8;
    localparam int GRP_NUM      = (HISTORY_BITS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W        = $clog2(GRP_SIZE + 1);
    localparam int PROD_W       = 14;
    localparam int THR_W        = 20;
    localparam int ADDR_W       = 6;
    localparam int DATA_W       = 64;
    localparam int PAT_W        = 64;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(64);
    localparam logic [CNT_W-1:0] SEEN_MAX = CNT_W'(HISTORY_BITS);

    localparam logic [2:0] REG_PAT_A = 3'd0;
    localparam logic [2:0] REG_LEN_A = 3'd1;
    localparam logic [2:0] REG_PAT_B = 3'd2;
    localparam logic [2:0] REG_LEN_B = 3'd3;
    localparam logic [2:0] REG_MAX   = 3'd4;

    typedef enum logic [1:0] {
        CLS_FEW,
        CLS_HIGH,
        CLS_LOW,
        CLS_MID
    } t_cls;

    typedef struct packed {
        logic pat_a;
        logic pat_b;
        logic msk_a;
        logic msk_b;
    } t_cell_cfg;

    typedef struct packed {
        logic load_grp;
        logic load_sum;
    } t_pop_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_score_ctl;

endpackage

/* sv/bpsd_if.sv */
// Handshake channels of the bit pattern score detector.
// Input bit channel and result channel; no dependencies.
interface bpsd_in_if;
    logic valid;
    logic ready;
    logic bit_in;

    modport source (output valid, output bit_in, input ready);
    modport sink (input valid, input bit_in, output ready);
endinterface

interface bpsd_out_if;
    logic        valid;
    logic        ready;
    logic        fire_a;
    logic        fire_b;
    logic        active_a;
    logic        active_b;
    logic [15:0] score_a;
    logic [15:0] score_b;

    modport source (output valid, output fire_a, output fire_b, output active_a,
                    output active_b, output score_a, output score_b, input ready);
    modport sink (input valid, input fire_a, input fire_b, input active_a,
                  input active_b, input score_a, input score_b, output ready);
endinterface

/* sv/bpsd_cell.sv */
// One history cell: holds one received bit and its match against both templates.
// Depends on bpsd_pkg.
module bpsd_cell import bpsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_shift,
    input  logic      i_prev,
    input  t_cell_cfg i_cfg,
    output logic      o_bit,
    output logic      o_match_a,
    output logic      o_match_b
);

    logic r_bit;
    logic r_match_a;
    logic r_match_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_match_a <= i_cfg.msk_a & ~(i_prev ^ i_cfg.pat_a);
            r_match_b <= i_cfg.msk_b & ~(i_prev ^ i_cfg.pat_b);
        end
    end

    assign o_bit     = r_bit;
    assign o_match_a = r_match_a;
    assign o_match_b = r_match_b;

endmodule

/* sv/bpsd_popcnt.sv */
// Two-stage registered match counter: group counts, then total.
// Depends on bpsd_pkg.
module bpsd_popcnt import bpsd_pkg::*; (
    input  logic                    i_clk,
    input  t_pop_ctl                i_ctl,
    input  logic [HISTORY_BITS-1:0] i_match,
    input  logic                    i_few,
    output logic [CNT_W-1:0]        o_count,
    output logic                    o_few
);

    logic [GRP_NUM*GRP_SIZE-1:0] w_pad;
    logic [GRP_W-1:0]            n_grp [GRP_NUM];
    logic [GRP_W-1:0]            r_grp [GRP_NUM];
    logic                        r_few_grp;
    logic [CNT_W-1:0]            n_sum;
    logic [CNT_W-1:0]            r_sum;
    logic                        r_few_sum;

    assign w_pad = (GRP_NUM*GRP_SIZE)'(i_match);

    always_comb begin
        for (int g = 0; g < GRP_NUM; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                n_grp[g] = n_grp[g] + GRP_W'(w_pad[g*GRP_SIZE + b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_grp) begin
            r_grp     <= n_grp;
            r_few_grp <= i_few;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            n_sum = n_sum + CNT_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sum) begin
            r_sum     <= n_sum;
            r_few_sum <= r_few_grp;
        end
    end

    assign o_count = r_sum;
    assign o_few   = r_few_sum;

endmodule

/* sv/bpsd_score.sv */
// Score channel: classifies the match count, then updates score and latch.
// Depends on bpsd_pkg.
module bpsd_score import bpsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_score_ctl         i_ctl,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_few,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [SCORE_W-1:0] i_max,
    input  logic [THR_W-1:0]   i_fire_thr,
    input  logic [THR_W-1:0]   i_rearm_thr,
    output logic [SCORE_W-1:0] o_score,
    output logic               o_active,
    output logic               o_fire
);

    logic [PROD_W-1:0]  w_cnt100;
    logic [PROD_W-1:0]  w_len61;
    logic [PROD_W-1:0]  w_cnt5;
    t_cls               n_cls;
    t_cls               r_cls;
    logic [SCORE_W-1:0] r_score;
    logic               r_lat;
    logic               r_fire;
    logic [SCORE_W-1:0] w_dec2;
    logic [SCORE_W-1:0] w_dec10;
    logic [SCORE_W:0]   w_raw;
    logic [SCORE_W-1:0] w_clamp;
    logic [THR_W-1:0]   w_s10;
    logic [SCORE_W-1:0] n_score;
    logic               n_lat;
    logic               n_fire;

    assign w_cnt100 = PROD_W'(i_count) * PROD_W'(100);
    assign w_len61  = PROD_W'(i_len) * PROD_W'(61);
    assign w_cnt5   = PROD_W'(i_count) * PROD_W'(5);

    always_comb begin
        priority if (i_few) begin
            n_cls = CLS_FEW;
        end else if (w_cnt100 > w_len61) begin
            n_cls = CLS_HIGH;
        end else if (w_cnt5 < PROD_W'(i_len)) begin
            n_cls = CLS_LOW;
        end else begin
            n_cls = CLS_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cls <= n_cls;
        end
    end

    assign w_dec2  = (r_score >= SCORE_W'(2)) ? r_score - SCORE_W'(2) : '0;
    assign w_dec10 = (r_score >= SCORE_W'(10)) ? r_score - SCORE_W'(10) : '0;

    always_comb begin
        unique case (r_cls)
            CLS_HIGH: w_raw = {1'b0, r_score} + (SCORE_W+1)'(15);
            CLS_LOW:  w_raw = {1'b0, w_dec10};
            default:  w_raw = {1'b0, w_dec2};
        endcase
    end

    assign w_clamp = (w_raw > {1'b0, i_max}) ? i_max : w_raw[SCORE_W-1:0];
    assign w_s10   = THR_W'(w_clamp) * THR_W'(10);

    always_comb begin
        n_score = w_clamp;
        n_lat   = r_lat;
        n_fire  = 1'b0;
        if (r_cls == CLS_FEW) begin
            n_score = w_dec2;
        end else begin
            if (w_s10 >= i_fire_thr && !r_lat) begin
                n_lat  = 1'b1;
                n_fire = 1'b1;
            end
            if (w_s10 < i_rearm_thr) begin
                n_lat = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_lat   <= 1'b0;
            r_fire  <= 1'b0;
        end else if (i_ctl.step) begin
            r_score <= n_score;
            r_lat   <= n_lat;
            r_fire  <= n_fire;
        end
    end

    assign o_score  = r_score;
    assign o_active = r_lat;
    assign o_fire   = r_fire;

endmodule

/* sv/bit_pattern_score_detector.sv */
// Bit pattern score detector, top level: APB registers, cell row, pipeline control.
// Depends on bpsd_pkg, bpsd_if, bpsd_cell, bpsd_popcnt, bpsd_score.
//
// Usage: received bits enter on i_in (valid/ready, field bit_in), one per item.
// Every accepted bit yields one result item on o_out: fire and active flags and
// the score of both templates after that bit.
// Templates, their lengths and max_score are written over the APB port at
// 8-byte spacing (pattern A, length A, pattern B, length B, max score); write
// them only while no item is in flight.
// A bit passes through the cell row, group count, total, classify and score
// update stages before its result is valid; the score update is the only loop.
// Throughput: one bit per cycle while the receiver keeps o_out.ready high.
// The five stages stall independently, so bits keep entering while a result
// waits, until the pipeline is full; then i_in.ready drops.
// Reset (synchronous, active low) clears history, scores, latches and the
// pipeline, and loads the default templates.
module bit_pattern_score_detector import bpsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpsd_in_if.sink           i_in,
    bpsd_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [PAT_W-1:0]   r_pat_a;
    logic [PAT_W-1:0]   r_pat_b;
    logic [LEN_W-1:0]   r_len_a;
    logic [LEN_W-1:0]   r_len_b;
    logic [SCORE_W-1:0] r_max;
    logic [THR_W-1:0]   r_fire_thr;
    logic [THR_W-1:0]   r_rearm_thr;
    logic [2:0]         w_reg;
    logic               w_wr;

    logic [LEN_W-1:0]   w_len_a;
    logic [LEN_W-1:0]   w_len_b;
    logic [CNT_W-1:0]   r_seen;
    logic [CNT_W-1:0]   n_seen;
    logic               r_few1_a;
    logic               r_few1_b;

    logic [HISTORY_BITS-1:0] w_hist;
    logic [HISTORY_BITS-1:0] w_match_a;
    logic [HISTORY_BITS-1:0] w_match_b;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_acc, w_t12, w_t23, w_t34, w_t45;

    t_pop_ctl   w_pop_ctl;
    t_score_ctl w_score_ctl;

    logic [CNT_W-1:0] w_cnt_a;
    logic [CNT_W-1:0] w_cnt_b;
    logic             w_few_a;
    logic             w_few_b;

    // APB registers
    assign pready = 1'b1;
    assign w_reg  = paddr[5:3];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_a <= PAT_W'(170);
            r_len_a <= LEN_W'(8);
            r_pat_b <= PAT_W'(124);
            r_len_b <= LEN_W'(10);
            r_max   <= SCORE_W'(100);
        end else if (w_wr) begin
            unique case (w_reg)
                REG_PAT_A: r_pat_a <= pwdata[PAT_W-1:0];
                REG_LEN_A: r_len_a <= pwdata[LEN_W-1:0];
                REG_PAT_B: r_pat_b <= pwdata[PAT_W-1:0];
                REG_LEN_B: r_len_b <= pwdata[LEN_W-1:0];
                REG_MAX:   r_max   <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PAT_A: prdata = DATA_W'(r_pat_a);
            REG_LEN_A: prdata = DATA_W'(r_len_a);
            REG_PAT_B: prdata = DATA_W'(r_pat_b);
            REG_LEN_B: prdata = DATA_W'(r_len_b);
            REG_MAX:   prdata = DATA_W'(r_max);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fire_thr  <= THR_W'(r_max) * THR_W'(9);
        r_rearm_thr <= THR_W'(r_max) * THR_W'(3);
    end

    // pipeline handshake
    assign w_rdy5 = ~r_v5 | o_out.ready;
    assign w_rdy4 = ~r_v4 | w_rdy5;
    assign w_rdy3 = ~r_v3 | w_rdy4;
    assign w_rdy2 = ~r_v2 | w_rdy3;
    assign w_rdy1 = ~r_v1 | w_rdy2;

    assign i_in.ready = w_rdy1;
    assign w_acc = i_in.valid & w_rdy1;
    assign w_t12 = r_v1 & w_rdy2;
    assign w_t23 = r_v2 & w_rdy3;
    assign w_t34 = r_v3 & w_rdy4;
    assign w_t45 = r_v4 & w_rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= w_acc | (r_v1 & ~w_t12);
            r_v2 <= w_t12 | (r_v2 & ~w_t23);
            r_v3 <= w_t23 | (r_v3 & ~w_t34);
            r_v4 <= w_t34 | (r_v4 & ~w_t45);
            r_v5 <= w_t45 | (r_v5 & ~o_out.ready);
        end
    end

    // lengths above 64 saturate
    assign w_len_a = (r_len_a > LEN_MAX) ? LEN_MAX : r_len_a;
    assign w_len_b = (r_len_b > LEN_MAX) ? LEN_MAX : r_len_b;
    assign n_seen  = (r_seen < SEEN_MAX) ? r_seen + CNT_W'(1) : r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_acc) begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_few1_a <= w_len_a > LEN_W'(n_seen);
            r_few1_b <= w_len_b > LEN_W'(n_seen);
        end
    end

    // cell row, newest bit in cell 0
    for (genvar i = 0; i < HISTORY_BITS; i++) begin : g_cell
        localparam logic [LEN_W-1:0] IDX = LEN_W'(i);
        t_cell_cfg w_cfg;
        logic      w_prev;

        assign w_cfg.pat_a = r_pat_a[i];
        assign w_cfg.pat_b = r_pat_b[i];
        assign w_cfg.msk_a = IDX < w_len_a;
        assign w_cfg.msk_b = IDX < w_len_b;

        if (i == 0) begin : g_head
            assign w_prev = i_in.bit_in;
        end else begin : g_body
            assign w_prev = w_hist[i-1];
        end

        bpsd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_acc),
            .i_prev    (w_prev),
            .i_cfg     (w_cfg),
            .o_bit     (w_hist[i]),
            .o_match_a (w_match_a[i]),
            .o_match_b (w_match_b[i])
        );
    end

    assign w_pop_ctl.load_grp = w_t12;
    assign w_pop_ctl.load_sum = w_t23;

    bpsd_popcnt u_pop_a (
        .i_clk   (i_clk),
        .i_ctl   (w_pop_ctl),
        .i_match (w_match_a),
        .i_few   (r_few1_a),
        .o_count (w_cnt_a),
        .o_few   (w_few_a)
    );

    bpsd_popcnt u_pop_b (
        .i_clk   (i_clk),
        .i_ctl   (w_pop_ctl),
        .i_match (w_match_b),
        .i_few   (r_few1_b),
        .o_count (w_cnt_b),
        .o_few   (w_few_b)
    );

    assign w_score_ctl.load = w_t34;
    assign w_score_ctl.step = w_t45;

    bpsd_score u_score_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_score_ctl),
        .i_count     (w_cnt_a),
        .i_few       (w_few_a),
        .i_len       (w_len_a),
        .i_max       (r_max),
        .i_fire_thr  (r_fire_thr),
        .i_rearm_thr (r_rearm_thr),
        .o_score     (o_out.score_a),
        .o_active    (o_out.active_a),
        .o_fire      (o_out.fire_a)
    );

    bpsd_score u_score_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_score_ctl),
        .i_count     (w_cnt_b),
        .i_few       (w_few_b),
        .i_len       (w_len_b),
        .i_max       (r_max),
        .i_fire_thr  (r_fire_thr),
        .i_rearm_thr (r_rearm_thr),
        .o_score     (o_out.score_b),
        .o_active    (o_out.active_b),
        .o_fire      (o_out.fire_b)
    );

    assign o_out.valid = r_v5;

endmodule

/* bench/bit_pattern_score_detector_test.sv */
// Testbench for bit_pattern_score_detector: directed and random bit streams
// scored against an in-bench predictor of both templates, under idling and stalls.
// Depends on bpsd_pkg, bpsd_if and the detector RTL.
module bit_pattern_score_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpsd_pkg::*;

    localparam int STUCK_LIMIT = 3000;

    typedef struct packed {
        logic        fire_a;
        logic        fire_b;
        logic        active_a;
        logic        active_b;
        logic [15:0] score_a;
        logic [15:0] score_b;
    } t_bit_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bpsd_in_if  in_ch ();
    bpsd_out_if out_ch ();

    bit_pattern_score_detector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and its copy of the registers
    logic [63:0]  history;
    int unsigned  seen_count;
    logic [63:0]  tpl_bits [2];
    logic [6:0]   tpl_len [2];
    int unsigned  tpl_score [2];
    logic         tpl_latched [2];
    int unsigned  max_score_cfg;

    // stimulus state
    int           tpl_cycle [2];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           stuck_cycles;
    int           mismatch_count;
    t_bit_result  expected_results [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic score_template(input int idx);
        int unsigned len;
        int unsigned s;
        int unsigned match_cnt;
        logic [63:0] diff;
        logic        fired;
        int          k;
        fired = 1'b0;
        len = (tpl_len[idx] > 7'd64) ? 32'd64 : 32'(tpl_len[idx]);
        s = tpl_score[idx];
        if (len > seen_count) begin
            tpl_score[idx] = (s >= 2) ? s - 2 : 0;
            return 1'b0;
        end
        diff = history ^ tpl_bits[idx];
        if (len < 64) diff = diff & ((64'd1 << len) - 64'd1);
        match_cnt = len;
        for (k = 0; k < 64; k++) match_cnt = match_cnt - 32'(diff[k]);
        if (100 * match_cnt > 61 * len) begin
            s = s + 15;
        end else if (5 * match_cnt < len) begin
            s = (s >= 10) ? s - 10 : 0;
        end else begin
            s = (s >= 2) ? s - 2 : 0;
        end
        if (s > max_score_cfg) s = max_score_cfg;
        tpl_score[idx] = s;
        if (10 * s >= 9 * max_score_cfg && !tpl_latched[idx]) begin
            tpl_latched[idx] = 1'b1;
            fired = 1'b1;
        end
        if (10 * s < 3 * max_score_cfg) tpl_latched[idx] = 1'b0;
        return fired;
    endfunction

    function automatic t_bit_result predict_bit(input logic b);
        t_bit_result r;
        history = {history[62:0], b};
        if (seen_count < HISTORY_BITS) seen_count++;
        r.fire_a   = score_template(0);
        r.fire_b   = score_template(1);
        r.active_a = tpl_latched[0];
        r.active_b = tpl_latched[1];
        r.score_a  = tpl_score[0][15:0];
        r.score_b  = tpl_score[1][15:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_bit_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("result item with no bit pending");
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                check_field("fire_a", 16'(want.fire_a), 16'(out_ch.fire_a));
                check_field("fire_b", 16'(want.fire_b), 16'(out_ch.fire_b));
                check_field("active_a", 16'(want.active_a), 16'(out_ch.active_a));
                check_field("active_b", 16'(want.active_b), 16'(out_ch.active_b));
                check_field("score_a", want.score_a, out_ch.score_a);
                check_field("score_b", want.score_b, out_ch.score_b);
            end
        end
        if (i_rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            expected_results.insert(expected_results.size(), predict_bit(in_ch.bit_in));
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_bit(input logic b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.bit_in <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_PAT_A: tpl_bits[0] = value;
            REG_LEN_A: tpl_len[0] = value[6:0];
            REG_PAT_B: tpl_bits[1] = value;
            REG_LEN_B: tpl_len[1] = value[6:0];
            REG_MAX:   max_score_cfg = 32'(value[15:0]);
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // periodic templates let a matching stream keep the score climbing
    task automatic program_random_templates(input bit widest);
        logic [63:0] pat;
        logic [6:0]  len;
        logic [2:0]  seed_bits;
        logic [15:0] top;
        int          period;
        int          t;
        int          k;
        drain_results();
        for (t = 0; t < 2; t++) begin
            period = $urandom_range(1, 4);
            seed_bits = 3'($urandom);
            if (period == 4) begin
                pat = {$urandom, $urandom};
            end else begin
                for (k = 0; k < 64; k++) pat[k] = seed_bits[k % period];
            end
            case ($urandom_range(7))
                0: len = 7'd0;
                1: len = 7'($urandom_range(65, 127));
                2: len = 7'd64;
                default: len = 7'($urandom_range(1, 16));
            endcase
            if (widest) len = 7'd64;
            if (period != 4) tpl_cycle[t] = period;
            else if (len == 0) tpl_cycle[t] = 1;
            else tpl_cycle[t] = (len > 7'd64) ? 64 : int'(len);
            write_reg((t == 0) ? REG_PAT_A : REG_PAT_B, pat);
            write_reg((t == 0) ? REG_LEN_A : REG_LEN_B, 64'(len));
        end
        case ($urandom_range(7))
            0: top = 16'd0;
            1: top = 16'd1;
            2: top = 16'hFFFF;
            default: top = 16'($urandom_range(20, 200));
        endcase
        if (widest) top = 16'hFFFF;
        write_reg(REG_MAX, 64'(top));
    endtask

    // segments that follow one template with rare flips, mixed with noise
    task automatic run_random_bits(input int count);
        int sent;
        int seg_len;
        int mode;
        int ph;
        int i;
        sent = 0;
        while (sent < count) begin
            mode = $urandom_range(99);
            seg_len = $urandom_range(8, 40);
            ph = 0;
            for (i = 0; i < seg_len && sent < count; i++) begin
                if (mode < 80) begin
                    send_bit(tpl_bits[(mode < 45) ? 0 : 1][ph] ^ ($urandom_range(15) == 0));
                    ph = (ph == 0) ? tpl_cycle[(mode < 45) ? 0 : 1] - 1 : ph - 1;
                end else begin
                    send_bit(1'($urandom_range(1)));
                end
                sent++;
            end
        end
    endtask

    task automatic test_directed_cases();
        logic [9:0] lead_in;
        int i;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // default templates; the first bits are too few for either length
        lead_in = 10'b0010101010;
        for (i = 9; i >= 0; i--) send_bit(lead_in[i]);
        // zero length on A, saturated length on B
        drain_results();
        write_reg(REG_MAX, 64'd15);
        write_reg(REG_LEN_A, 64'd0);
        write_reg(REG_LEN_B, 64'd127);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        // one-bit template: fire, decay, re-arm, fire again
        drain_results();
        write_reg(REG_PAT_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_LEN_A, 64'd1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        // score above a lowered max, then a zero max
        drain_results();
        write_reg(REG_MAX, 64'd5);
        send_bit(1'b1);
        drain_results();
        write_reg(REG_MAX, 64'd0);
        send_bit(1'b1);
        send_bit(1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input bit widest);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        program_random_templates(1'b0);
        run_random_bits(80);
        program_random_templates(widest);
        run_random_bits(80);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_random_templates(1'b0);
        @(posedge i_clk);
        hold_left = 250;
        @(negedge i_clk);
        run_random_bits(40);
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        run_random_bits(20);
        drain_results();
        run_random_bits(20);
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.bit_in = 1'b0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_left = 0;
        stuck_cycles = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        history = '0;
        seen_count = 0;
        max_score_cfg = 100;
        tpl_bits[0] = 64'd170;
        tpl_len[0] = 7'd8;
        tpl_bits[1] = 64'd124;
        tpl_len[1] = 7'd10;
        tpl_score[0] = 0;
        tpl_score[1] = 0;
        tpl_latched[0] = 1'b0;
        tpl_latched[1] = 1'b0;
        tpl_cycle[0] = 8;
        tpl_cycle[1] = 10;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_traffic(0, 0, 1'b0);
        test_random_traffic(63, 0, 1'b0);
        test_random_traffic(0, 63, 1'b0);
        test_random_traffic(30, 30, 1'b1);
        test_output_backpressure();
        test_sender_pause();

        drain_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/bpsd_pkg.sv
sv/bpsd_if.sv
sv/bpsd_cell.sv
sv/bpsd_popcnt.sv
sv/bpsd_score.sv
sv/bit_pattern_score_detector.sv
bench/bit_pattern_score_detector_test.sv
